// ----- src/covariance_matrix_engine_unit_defines.svh -----
// Assertion helpers shared by the RTL.
`ifndef COVARIANCE_MATRIX_ENGINE_UNIT_DEFINES_SVH
`define COVARIANCE_MATRIX_ENGINE_UNIT_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define CME_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cme same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define CME_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cme next-cycle check failed");

`endif

// ----- src/cme_pkg.sv -----
package cme_pkg;
  localparam int SAMPLE_W   = 24;
  localparam int COV_W      = 50;
  localparam int IDX_W      = 3;
  localparam int ROWS_REG_W = 11;
  localparam int COLS_REG_W = 4;
  localparam int CFG_DATA_W = 11;
  localparam int CFG_IDX_W  = 2;

  localparam int DEF_MAX_ROWS = 1024;
  localparam int DEF_MAX_COLS = 8;

  localparam logic [CFG_IDX_W-1:0] REG_NUM_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_COLS = 2'd1;
endpackage

// ----- src/cme_if.sv -----
interface cme_in_if;
  import cme_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample_value;
  modport source (output valid, output sample_value, input ready);
  modport sink   (input valid, input sample_value, output ready);
endinterface

interface cme_out_if;
  import cme_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [IDX_W-1:0]        row_index;
  logic [IDX_W-1:0]        col_index;
  logic signed [COV_W-1:0] covariance;
  logic                    last_result;
  modport source (output valid, output row_index, output col_index,
                  output covariance, output last_result, input ready);
  modport sink   (input valid, input row_index, input col_index,
                  input covariance, input last_result, output ready);
endinterface

// ----- src/cme_ram.sv -----
module cme_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 8192
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- src/cme_div.sv -----
// Restoring divider: signed dividend by unsigned divisor, one bit a cycle,
// quotient truncated toward zero.
module cme_div #(
  parameter int W  = 61,
  parameter int DW = 11
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic signed [W-1:0] dividend,
  input  logic [DW-1:0]       divisor,
  output logic                busy,
  output logic                done,
  output logic signed [W-1:0] quotient
);
  localparam int CNT_W = $clog2(W + 1);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              neg_r, neg_nxt;
  logic [W-1:0]      quo_r, quo_nxt;
  logic [DW-1:0]     rem_r, rem_nxt;
  logic [DW-1:0]     dvs_r, dvs_nxt;
  logic [W-1:0]      res_r, res_nxt;
  logic [DW:0]       rem_sh;
  logic              fits;
  logic [W-1:0]      quo_step;

  always_comb begin
    rem_sh   = {rem_r, quo_r[W-1]};
    fits     = rem_sh >= {1'b0, dvs_r};
    quo_step = {quo_r[W-2:0], fits};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    neg_nxt  = neg_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    res_nxt  = res_r;
    if (start && !busy_r) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(W);
      neg_nxt  = dividend[W-1];
      quo_nxt  = dividend[W-1] ? W'(-dividend) : W'(dividend);
      rem_nxt  = '0;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = fits ? DW'(rem_sh - {1'b0, dvs_r}) : rem_sh[DW-1:0];
      quo_nxt = quo_step;
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
        res_nxt  = neg_r ? W'(-quo_step) : quo_step;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    neg_r <= neg_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    res_r <= res_nxt;
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = res_r;
endmodule

// ----- src/covariance_matrix_engine_unit.sv -----
// Population covariance engine. Words arrive on in_ch one sample at a time,
// row-major: num_rows observations of num_cols variables, signed with 12
// fraction bits. Each accepted sample is written to the store. After the last
// sample of a set the block drops ready and computes: for each column it sums
// the stored column and divides by num_rows in the shared bit-serial divider,
// then for each of the num_cols*num_cols entries it walks the rows through one
// 25x25 multiplier (per row: two reads of the single RAM port, subtract,
// multiply, accumulate) and divides again. Each result is held until out_ch
// takes it, and computation waits for that. Results come row-major with
// last_result on the final entry; both means and covariances are truncated
// toward zero. Writing either configuration register drops a partly loaded
// set. Zero counts act as 1 and oversized counts saturate to MAX_ROWS /
// MAX_COLS.
`include "covariance_matrix_engine_unit_defines.svh"

module covariance_matrix_engine_unit #(
  parameter int MAX_ROWS = cme_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS = cme_pkg::DEF_MAX_COLS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  cme_in_if.sink                          in_ch,
  cme_out_if.source                       out_ch,
  input  logic                            cfg_we,
  input  logic [cme_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [cme_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import cme_pkg::*;

  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = DEPTH > 1 ? $clog2(DEPTH) : 1;
  localparam int TW    = $clog2(DEPTH + 1);
  localparam int CIW   = MAX_COLS > 1 ? $clog2(MAX_COLS) : 1;
  localparam int DFW   = SAMPLE_W + 1;
  localparam int PW    = 2 * DFW;
  localparam int ACW   = PW + $clog2(MAX_ROWS + 1) + 1;

  typedef enum logic [3:0] {
    S_LOAD, S_MRD, S_MACC, S_MDST, S_MDW,
    S_CA, S_CB, S_CC, S_CD, S_CE, S_CDST, S_CDW, S_OUT
  } state_t;

  state_t                   state_r, state_nxt;
  logic [ROWS_REG_W-1:0]    num_rows_r;
  logic [COLS_REG_W-1:0]    num_cols_r;
  logic [ROWS_REG_W-1:0]    eff_rows;
  logic [COLS_REG_W-1:0]    eff_cols;
  logic [TW-1:0]            total;
  logic [AW-1:0]            load_cnt_r, load_cnt_nxt;
  logic [ROWS_REG_W-1:0]    row_r, row_nxt;
  logic [AW-1:0]            base_r, base_nxt;
  logic [CIW-1:0]           ci_r, ci_nxt;
  logic [CIW-1:0]           cj_r, cj_nxt;
  logic signed [ACW-1:0]    acc_r, acc_nxt;
  logic signed [DFW-1:0]    di_r, di_nxt;
  logic signed [DFW-1:0]    dj_r, dj_nxt;
  logic signed [PW-1:0]     prod_r;
  logic [SAMPLE_W-1:0]      mean_r [MAX_COLS];
  logic [SAMPLE_W-1:0]      mean_rd;
  logic                     mean_we;
  logic                     last_row, last_ci, last_cj;

  logic                     ram_we;
  logic [AW-1:0]            ram_raddr;
  logic [SAMPLE_W-1:0]      ram_rdata;
  logic signed [DFW-1:0]    diff;

  logic                     div_start, div_busy, div_done;
  logic signed [ACW-1:0]    div_q;

  logic                     out_valid_r;
  logic [IDX_W-1:0]         out_row_r, out_col_r;
  logic signed [COV_W-1:0]  out_cov_r;
  logic                     out_last_r;
  logic                     in_hs, out_hs;

  // Effective register values
  always_comb begin
    if (num_rows_r == '0) eff_rows = ROWS_REG_W'(1);
    else if (int'(num_rows_r) > MAX_ROWS) eff_rows = ROWS_REG_W'(MAX_ROWS);
    else eff_rows = num_rows_r;
    if (num_cols_r == '0) eff_cols = COLS_REG_W'(1);
    else if (int'(num_cols_r) > MAX_COLS) eff_cols = COLS_REG_W'(MAX_COLS);
    else eff_cols = num_cols_r;
    total = TW'(int'(eff_rows) * int'(eff_cols));
  end

  assign in_hs    = in_ch.valid && in_ch.ready;
  assign out_hs   = out_ch.valid && out_ch.ready;
  assign last_row = row_r == eff_rows - 1'b1;
  assign last_ci  = int'(ci_r) == int'(eff_cols) - 1;
  assign last_cj  = int'(cj_r) == int'(eff_cols) - 1;

  cme_ram #(.WIDTH(SAMPLE_W), .DEPTH(DEPTH)) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(load_cnt_r),
    .wdata(in_ch.sample_value),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  cme_div #(.W(ACW), .DW(ROWS_REG_W)) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .dividend(acc_r),
    .divisor (eff_rows),
    .busy    (div_busy),
    .done    (div_done),
    .quotient(div_q)
  );

  // Single read port on the means, column i then column j
  assign mean_rd = mean_r[(state_r == S_CB) ? ci_r : cj_r];
  assign diff    = $signed({ram_rdata[SAMPLE_W-1], ram_rdata})
                 - $signed({mean_rd[SAMPLE_W-1], mean_rd});

  always_comb begin
    state_nxt    = state_r;
    load_cnt_nxt = load_cnt_r;
    row_nxt      = row_r;
    base_nxt     = base_r;
    ci_nxt       = ci_r;
    cj_nxt       = cj_r;
    acc_nxt      = acc_r;
    di_nxt       = di_r;
    dj_nxt       = dj_r;
    ram_we       = 1'b0;
    ram_raddr    = base_r + AW'(cj_r);
    div_start    = 1'b0;
    mean_we      = 1'b0;
    case (state_r)
      S_LOAD: begin
        if (in_hs) begin
          ram_we = 1'b1;
          if (TW'(load_cnt_r) == total - 1'b1) begin
            load_cnt_nxt = '0;
            state_nxt    = S_MRD;
            row_nxt      = '0;
            base_nxt     = '0;
            cj_nxt       = '0;
            acc_nxt      = '0;
          end else begin
            load_cnt_nxt = load_cnt_r + 1'b1;
          end
        end
      end
      S_MRD: state_nxt = S_MACC;
      S_MACC: begin
        acc_nxt = acc_r + ACW'($signed(ram_rdata));
        if (last_row) begin
          state_nxt = S_MDST;
        end else begin
          row_nxt   = row_r + 1'b1;
          base_nxt  = base_r + AW'(eff_cols);
          state_nxt = S_MRD;
        end
      end
      S_MDST: begin
        div_start = 1'b1;
        state_nxt = S_MDW;
      end
      S_MDW: begin
        if (div_done) begin
          mean_we  = 1'b1;
          row_nxt  = '0;
          base_nxt = '0;
          acc_nxt  = '0;
          if (last_cj) begin
            ci_nxt    = '0;
            cj_nxt    = '0;
            state_nxt = S_CA;
          end else begin
            cj_nxt    = cj_r + 1'b1;
            state_nxt = S_MRD;
          end
        end
      end
      S_CA: begin
        ram_raddr = base_r + AW'(ci_r);
        state_nxt = S_CB;
      end
      S_CB: begin
        di_nxt    = diff;
        state_nxt = S_CC;
      end
      S_CC: begin
        dj_nxt    = diff;
        state_nxt = S_CD;
      end
      S_CD: state_nxt = S_CE;
      S_CE: begin
        acc_nxt = acc_r + ACW'(prod_r);
        if (last_row) begin
          state_nxt = S_CDST;
        end else begin
          row_nxt   = row_r + 1'b1;
          base_nxt  = base_r + AW'(eff_cols);
          state_nxt = S_CA;
        end
      end
      S_CDST: begin
        div_start = 1'b1;
        state_nxt = S_CDW;
      end
      S_CDW: begin
        if (div_done) state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_ch.ready) begin
          row_nxt  = '0;
          base_nxt = '0;
          acc_nxt  = '0;
          if (last_ci && last_cj) begin
            state_nxt = S_LOAD;
          end else begin
            state_nxt = S_CA;
            if (last_cj) begin
              cj_nxt = '0;
              ci_nxt = ci_r + 1'b1;
            end else begin
              cj_nxt = cj_r + 1'b1;
            end
          end
        end
      end
      default: state_nxt = S_LOAD;
    endcase
    // a register write restarts loading
    if (cfg_we && (cfg_index == REG_NUM_ROWS || cfg_index == REG_NUM_COLS)) begin
      load_cnt_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      num_rows_r  <= ROWS_REG_W'(1);
      num_cols_r  <= COLS_REG_W'(1);
      load_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      load_cnt_r  <= load_cnt_nxt;
      out_valid_r <= (state_r == S_CDW && div_done) ||
                     (out_valid_r && !out_ch.ready);
      if (cfg_we && cfg_index == REG_NUM_ROWS) begin
        num_rows_r <= cfg_wdata[ROWS_REG_W-1:0];
      end
      if (cfg_we && cfg_index == REG_NUM_COLS) begin
        num_cols_r <= cfg_wdata[COLS_REG_W-1:0];
      end
    end
    row_r  <= row_nxt;
    base_r <= base_nxt;
    ci_r   <= ci_nxt;
    cj_r   <= cj_nxt;
    acc_r  <= acc_nxt;
    di_r   <= di_nxt;
    dj_r   <= dj_nxt;
    prod_r <= di_r * dj_r;
    if (mean_we) begin
      mean_r[cj_r] <= div_q[SAMPLE_W-1:0];
    end
    if (state_r == S_CDW && div_done) begin
      out_row_r  <= IDX_W'(ci_r);
      out_col_r  <= IDX_W'(cj_r);
      out_cov_r  <= div_q[COV_W-1:0];
      out_last_r <= last_ci && last_cj;
    end
  end

  assign in_ch.ready        = state_r == S_LOAD;
  assign out_ch.valid       = out_valid_r;
  assign out_ch.row_index   = out_row_r;
  assign out_ch.col_index   = out_col_r;
  assign out_ch.covariance  = out_cov_r;
  assign out_ch.last_result = out_last_r;

  `CME_ASSERT_NOW(a_load_excl_out, in_ch.ready, !out_ch.valid)
  `CME_ASSERT_NXT(a_last_to_load, out_hs && out_ch.last_result, in_ch.ready)
  `CME_ASSERT_NOW(a_cnt_in_set, in_ch.ready, TW'(load_cnt_r) < total)
  `CME_ASSERT_NOW(a_div_idle_start, div_start, !div_busy)
endmodule
